### design/sds_pkg.sv
// ----------------------------------------------------------------------------
// sds_pkg: shared types and constants of the stroke dab spacer
// Field widths, fixed-point sizes, command codes, state codes and the structs
// that pass between the front, the queue, the back and the divider.
// ----------------------------------------------------------------------------
package sds_pkg;

   // Fixed-point and limit constants
   localparam int FRAC_BITS  = 8;
   localparam int MAX_DABS   = 64;
   localparam int COORD_W    = 16;
   localparam int SPACING_W  = 10;
   localparam int DELTA_W    = COORD_W + 1;
   localparam int SQ_W       = 2 * DELTA_W;
   localparam int LEN_W      = DELTA_W + FRAC_BITS;
   localparam int SQRT_STEPS = LEN_W;
   localparam int STEP_W     = $clog2(SQRT_STEPS);
   localparam int REM_W      = LEN_W + 3;
   localparam int SPF_W      = SPACING_W + FRAC_BITS;
   localparam int CARRY_W    = SPF_W;
   localparam int DIST_W     = LEN_W + 1;
   localparam int N_W        = $clog2(MAX_DABS + 1);
   localparam int T_W        = SPF_W + N_W + 1;
   localparam int MUL_W      = DELTA_W + T_W;
   localparam int Q_W        = T_W + 2;

   // Divider sizes
   localparam int DVD_W      = MUL_W;
   localparam int DVS_W      = LEN_W;
   localparam int DIV_CNT_W  = $clog2(DVD_W);

   // Queue sizes
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Configuration port
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam logic REG_SPACING = 1'b0;
   localparam logic [SPACING_W-1:0] SPACING_RESET = SPACING_W'(1);

   // Event kinds on the input channel
   localparam logic [1:0] EVT_PRESS   = 2'd0;
   localparam logic [1:0] EVT_MOVE    = 2'd1;
   localparam logic [1:0] EVT_RELEASE = 2'd2;

   typedef struct packed {
      logic [1:0]                 req_type;
      logic signed [COORD_W-1:0]  pointer_x;
      logic signed [COORD_W-1:0]  pointer_y;
      logic                       left_button;
      logic                       layer_visible;
   } req_item_type;

   typedef struct packed {
      logic signed [COORD_W-1:0]  dab_x;
      logic signed [COORD_W-1:0]  dab_y;
      logic                       last;
      logic                       truncated;
   } rsp_item_type;

   typedef enum logic {
      CMD_PRESS,
      CMD_MOVE
   } cmd_type;

   typedef struct packed {
      cmd_type                    cmd;
      logic signed [COORD_W-1:0]  x;
      logic signed [COORD_W-1:0]  y;
   } queue_entry_type;

   typedef struct packed {
      logic            valid;
      queue_entry_type entry;
   } queue_push_type;

   typedef struct packed {
      logic            valid;
      queue_entry_type entry;
   } queue_head_type;

   typedef struct packed {
      logic              start;
      logic [DVD_W-1:0]  dividend;
      logic [DVS_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DVD_W-1:0]  quotient;
      logic [DVS_W-1:0]  remainder;
   } div_rsp_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_SQUARE,
      BK_SUM,
      BK_SQRT,
      BK_DIV_N,
      BK_DIV_XS,
      BK_DIV_YS,
      BK_DIV_X1,
      BK_DIV_Y1,
      BK_WALK
   } back_state_type;

   typedef enum logic [1:0] {
      PH_MUL,
      PH_START,
      PH_WAIT
   } div_phase_type;

endpackage

### design/sds_front.sv
// ----------------------------------------------------------------------------
// sds_front: event intake and classification
// Accepts pointer events, tracks the drag flag and forwards presses and moves
// that produce work to the command queue. Ignored events are dropped here.
// ----------------------------------------------------------------------------
module sds_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  sds_pkg::req_item_type req_item,
   input  logic                  queue_full,
   output sds_pkg::queue_push_type push
);
   import sds_pkg::*;

   logic drag_ff;
   logic drag_in;
   logic accept;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   // Classify the item and update the drag flag
   always_comb begin
      drag_in         = drag_ff;
      push.valid      = 1'b0;
      push.entry.cmd  = CMD_MOVE;
      push.entry.x    = req_item.pointer_x;
      push.entry.y    = req_item.pointer_y;
      if (accept) begin
         unique case (req_item.req_type)
            EVT_PRESS: begin
               if (req_item.left_button && req_item.layer_visible) begin
                  drag_in        = 1'b1;
                  push.valid     = 1'b1;
                  push.entry.cmd = CMD_PRESS;
               end
            end
            EVT_MOVE: begin
               if (drag_ff && req_item.layer_visible) begin
                  push.valid = 1'b1;
               end
            end
            EVT_RELEASE: begin
               if (req_item.left_button) begin
                  drag_in = 1'b0;
               end
            end
            default: begin
               drag_in = drag_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drag_ff <= 1'b0;
      end else begin
         drag_ff <= drag_in;
      end
   end

endmodule

### design/sds_queue.sv
// ----------------------------------------------------------------------------
// sds_queue: command queue between front and back
// A short first-in first-out buffer of presses and moves so that the front
// keeps taking events while the back works through a long move.
// ----------------------------------------------------------------------------
module sds_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  sds_pkg::queue_push_type push,
   input  logic                    pop,
   output logic                    full,
   output sds_pkg::queue_head_type head
);
   import sds_pkg::*;

   queue_entry_type     slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.entry = slot_ff[rd_ptr_ff];
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head.valid;

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed item
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push.entry;
      end
   end

endmodule

### design/sds_divider.sv
// ----------------------------------------------------------------------------
// sds_divider: iterative unsigned divider
// Restoring division, one quotient bit per cycle. A start pulse loads the
// operands; done pulses for one cycle when quotient and remainder are ready.
// ----------------------------------------------------------------------------
module sds_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  sds_pkg::div_req_type div_req,
   output sds_pkg::div_rsp_type div_rsp
);
   import sds_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DVD_W-1:0]      quo_ff, quo_in;
   logic [DVS_W-1:0]      rem_ff, rem_in;
   logic [DVS_W-1:0]      dvs_ff, dvs_in;
   logic [DVS_W:0]        rem_shift;
   logic [DVS_W:0]        rem_diff;
   logic                  fits;

   assign rem_shift = {rem_ff, quo_ff[DVD_W-1]};
   assign rem_diff  = rem_shift - {1'b0, dvs_ff};
   assign fits      = (rem_shift >= {1'b0, dvs_ff});

   // One restoring step per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DVD_W-2:0], fits};
         rem_in = fits ? rem_diff[DVS_W-1:0] : rem_shift[DVS_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

### design/sds_back.sv
// ----------------------------------------------------------------------------
// sds_back: stroke geometry sequencer
// Takes commands from the queue, measures the segment with a bit-serial
// square root, splits it with the shared divider and walks the dabs out one
// per cycle through the output register while the receiver takes them.
// ----------------------------------------------------------------------------
module sds_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [sds_pkg::SPACING_W-1:0] spacing,
   input  sds_pkg::queue_head_type  head,
   output logic                     pop,
   output sds_pkg::div_req_type     div_req,
   input  sds_pkg::div_rsp_type     div_rsp,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output sds_pkg::rsp_item_type    rsp_item
);
   import sds_pkg::*;

   back_state_type              state_ff, state_in;
   div_phase_type               phase_ff, phase_in;

   // Persistent stroke state
   logic signed [COORD_W-1:0]   anchor_x_ff, anchor_x_in;
   logic signed [COORD_W-1:0]   anchor_y_ff, anchor_y_in;
   logic [CARRY_W-1:0]          carried_ff, carried_in;

   // Working registers of one move
   logic signed [COORD_W-1:0]   ax_ff, ax_in;
   logic signed [COORD_W-1:0]   ay_ff, ay_in;
   logic signed [DELTA_W-1:0]   dx_ff, dx_in;
   logic signed [DELTA_W-1:0]   dy_ff, dy_in;
   logic [CARRY_W-1:0]          saved_ff, saved_in;
   logic [SQ_W-1:0]             sqx_ff, sqx_in;
   logic [SQ_W-1:0]             sqy_ff, sqy_in;
   logic [SQ_W-1:0]             s_ff, s_in;
   logic [LEN_W-1:0]            root_ff, root_in;
   logic [REM_W-1:0]            srem_ff, srem_in;
   logic [STEP_W-1:0]           step_ff, step_in;
   logic signed [MUL_W-1:0]     prod_ff, prod_in;
   logic [N_W-1:0]              n_ff, n_in;
   logic [N_W-1:0]              k_ff, k_in;
   logic                        trunc_ff, trunc_in;
   logic signed [T_W-1:0]       t_ff, t_in;
   logic signed [Q_W-1:0]       qsx_ff, qsx_in, qsy_ff, qsy_in;
   logic signed [Q_W-1:0]       qx_ff, qx_in, qy_ff, qy_in;
   logic [LEN_W-1:0]            rsx_ff, rsx_in, rsy_ff, rsy_in;
   logic [LEN_W-1:0]            rx_ff, rx_in, ry_ff, ry_in;

   // Output register
   logic                        rsp_valid_ff, rsp_valid_in;
   rsp_item_type                rsp_item_ff, rsp_item_in;

   // Combinational helpers
   logic                        out_free;
   logic                        out_load;
   rsp_item_type                out_item;
   logic [SPACING_W-1:0]        spc;
   logic [SPF_W-1:0]            spf;
   logic [DIST_W-1:0]           total_dist;
   logic signed [SQ_W-1:0]      dx_wide, dy_wide;
   logic signed [SQ_W-1:0]      sqx_full, sqy_full;
   logic [REM_W-1:0]            srem_shift, sqrt_trial;
   logic                        sqrt_fits;
   logic signed [MUL_W-1:0]     mul_a, mul_b, mul_res;
   logic                        prod_neg;
   logic [MUL_W-1:0]            prod_mag;
   logic signed [Q_W-1:0]       div_q, floor_q;
   logic [LEN_W-1:0]            div_r, floor_r;
   logic                        ntot_zero, ntot_over;
   logic [LEN_W:0]              rx_sum, ry_sum, rx_wrap, ry_wrap;
   logic                        rx_carry, ry_carry;
   logic signed [Q_W-1:0]       px_sum, py_sum, px_adj, py_adj;
   logic                        at_anchor;
   logic                        div_capture;

   assign spc        = (spacing == '0) ? SPACING_W'(1) : spacing;
   assign spf        = {spc, {FRAC_BITS{1'b0}}};
   assign total_dist = DIST_W'(saved_ff) + DIST_W'(root_ff);
   assign out_free   = !rsp_valid_ff || rsp_ready;

   // Squares of the deltas
   assign dx_wide  = {{(SQ_W-DELTA_W){dx_ff[DELTA_W-1]}}, dx_ff};
   assign dy_wide  = {{(SQ_W-DELTA_W){dy_ff[DELTA_W-1]}}, dy_ff};
   assign sqx_full = dx_wide * dx_wide;
   assign sqy_full = dy_wide * dy_wide;

   // Square root step: two radicand bits per cycle
   assign srem_shift = {srem_ff[REM_W-3:0], s_ff[SQ_W-1:SQ_W-2]};
   assign sqrt_trial = REM_W'({root_ff, 2'b01});
   assign sqrt_fits  = (srem_shift >= sqrt_trial);

   // Shared multiplier: delta times step or first offset
   always_comb begin
      mul_a = $signed({{(MUL_W-DELTA_W){dx_ff[DELTA_W-1]}}, dx_ff});
      mul_b = $signed(MUL_W'(spf));
      unique case (state_ff)
         BK_DIV_XS: begin
            mul_a = $signed({{(MUL_W-DELTA_W){dx_ff[DELTA_W-1]}}, dx_ff});
            mul_b = $signed(MUL_W'(spf));
         end
         BK_DIV_YS: begin
            mul_a = $signed({{(MUL_W-DELTA_W){dy_ff[DELTA_W-1]}}, dy_ff});
            mul_b = $signed(MUL_W'(spf));
         end
         BK_DIV_X1: begin
            mul_a = $signed({{(MUL_W-DELTA_W){dx_ff[DELTA_W-1]}}, dx_ff});
            mul_b = $signed({{(MUL_W-T_W){t_ff[T_W-1]}}, t_ff});
         end
         BK_DIV_Y1: begin
            mul_a = $signed({{(MUL_W-DELTA_W){dy_ff[DELTA_W-1]}}, dy_ff});
            mul_b = $signed({{(MUL_W-T_W){t_ff[T_W-1]}}, t_ff});
         end
         default: begin
            mul_a = $signed({{(MUL_W-DELTA_W){dx_ff[DELTA_W-1]}}, dx_ff});
            mul_b = $signed(MUL_W'(spf));
         end
      endcase
   end
   assign mul_res  = mul_a * mul_b;
   assign prod_neg = prod_ff[MUL_W-1];
   assign prod_mag = prod_neg ? MUL_W'(-prod_ff) : MUL_W'(prod_ff);

   // Turn the magnitude quotient into a floor quotient and remainder
   assign div_q = $signed(div_rsp.quotient[Q_W-1:0]);
   assign div_r = div_rsp.remainder[LEN_W-1:0];
   always_comb begin
      if (!prod_neg) begin
         floor_q = div_q;
         floor_r = div_r;
      end else if (div_r == '0) begin
         floor_q = -div_q;
         floor_r = '0;
      end else begin
         floor_q = -div_q - Q_W'(1);
         floor_r = root_ff - div_r;
      end
   end

   assign ntot_zero = (div_rsp.quotient == '0);
   assign ntot_over = (div_rsp.quotient > DVD_W'(MAX_DABS));

   // Dab walk: remainder accumulation and rounding toward zero
   assign rx_sum   = {1'b0, rx_ff} + {1'b0, rsx_ff};
   assign ry_sum   = {1'b0, ry_ff} + {1'b0, rsy_ff};
   assign rx_carry = (rx_sum >= {1'b0, root_ff});
   assign ry_carry = (ry_sum >= {1'b0, root_ff});
   assign rx_wrap  = rx_sum - {1'b0, root_ff};
   assign ry_wrap  = ry_sum - {1'b0, root_ff};
   assign px_sum   = $signed({{(Q_W-COORD_W){ax_ff[COORD_W-1]}}, ax_ff}) + qx_ff;
   assign py_sum   = $signed({{(Q_W-COORD_W){ay_ff[COORD_W-1]}}, ay_ff}) + qy_ff;
   assign px_adj   = (px_sum[Q_W-1] && rx_ff != '0) ? px_sum + Q_W'(1) : px_sum;
   assign py_adj   = (py_sum[Q_W-1] && ry_ff != '0) ? py_sum + Q_W'(1) : py_sum;
   assign at_anchor = (root_ff == '0) || t_ff[T_W-1];

   assign div_capture = (phase_ff == PH_WAIT) && div_rsp.done;

   // Next state
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (head.valid && head.entry.cmd == CMD_MOVE) begin
               state_in = BK_SQUARE;
            end
         end
         BK_SQUARE: state_in = BK_SUM;
         BK_SUM:    state_in = BK_SQRT;
         BK_SQRT: begin
            if (step_ff == STEP_W'(SQRT_STEPS - 1)) begin
               state_in = BK_DIV_N;
               phase_in = PH_MUL;
            end
         end
         BK_DIV_N, BK_DIV_XS, BK_DIV_YS, BK_DIV_X1, BK_DIV_Y1: begin
            unique case (phase_ff)
               PH_MUL:   phase_in = PH_START;
               PH_START: phase_in = PH_WAIT;
               PH_WAIT: begin
                  if (div_rsp.done) begin
                     phase_in = PH_MUL;
                     unique case (state_ff)
                        BK_DIV_N: begin
                           if (ntot_zero) begin
                              state_in = BK_IDLE;
                           end else if (root_ff == '0) begin
                              state_in = BK_WALK;
                           end else begin
                              state_in = BK_DIV_XS;
                           end
                        end
                        BK_DIV_XS: state_in = BK_DIV_YS;
                        BK_DIV_YS: state_in = BK_DIV_X1;
                        BK_DIV_X1: state_in = BK_DIV_Y1;
                        default:   state_in = BK_WALK;
                     endcase
                  end
               end
               default: phase_in = PH_MUL;
            endcase
         end
         BK_WALK: begin
            if (out_free && k_ff == n_ff) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // Sequencer outputs: queue pop, divider start, dab load
   always_comb begin
      pop              = 1'b0;
      out_load         = 1'b0;
      out_item.dab_x   = head.entry.x;
      out_item.dab_y   = head.entry.y;
      out_item.last    = 1'b1;
      out_item.truncated = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = prod_mag;
      div_req.divisor  = root_ff;
      if (state_ff == BK_DIV_N) begin
         div_req.dividend = DVD_W'(total_dist);
         div_req.divisor  = DVS_W'(spf);
      end
      unique case (state_ff)
         BK_IDLE: begin
            if (head.valid) begin
               if (head.entry.cmd == CMD_MOVE) begin
                  pop = 1'b1;
               end else if (out_free) begin
                  pop      = 1'b1;
                  out_load = 1'b1;
               end
            end
         end
         BK_DIV_N, BK_DIV_XS, BK_DIV_YS, BK_DIV_X1, BK_DIV_Y1: begin
            div_req.start = (phase_ff == PH_START);
         end
         BK_WALK: begin
            out_load           = out_free;
            out_item.dab_x     = at_anchor ? ax_ff : px_adj[COORD_W-1:0];
            out_item.dab_y     = at_anchor ? ay_ff : py_adj[COORD_W-1:0];
            out_item.last      = (k_ff == n_ff);
            out_item.truncated = trunc_ff;
         end
         default: begin
            pop = 1'b0;
         end
      endcase
   end

   // Datapath next values
   always_comb begin
      anchor_x_in = anchor_x_ff;
      anchor_y_in = anchor_y_ff;
      carried_in  = carried_ff;
      ax_in       = ax_ff;
      ay_in       = ay_ff;
      dx_in       = dx_ff;
      dy_in       = dy_ff;
      saved_in    = saved_ff;
      sqx_in      = sqx_ff;
      sqy_in      = sqy_ff;
      s_in        = s_ff;
      root_in     = root_ff;
      srem_in     = srem_ff;
      step_in     = step_ff;
      prod_in     = prod_ff;
      n_in        = n_ff;
      k_in        = k_ff;
      trunc_in    = trunc_ff;
      t_in        = t_ff;
      qsx_in      = qsx_ff;
      qsy_in      = qsy_ff;
      qx_in       = qx_ff;
      qy_in       = qy_ff;
      rsx_in      = rsx_ff;
      rsy_in      = rsy_ff;
      rx_in       = rx_ff;
      ry_in       = ry_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (pop) begin
               anchor_x_in = head.entry.x;
               anchor_y_in = head.entry.y;
               if (head.entry.cmd == CMD_PRESS) begin
                  carried_in = '0;
               end else begin
                  ax_in    = anchor_x_ff;
                  ay_in    = anchor_y_ff;
                  dx_in    = DELTA_W'(head.entry.x) - DELTA_W'(anchor_x_ff);
                  dy_in    = DELTA_W'(head.entry.y) - DELTA_W'(anchor_y_ff);
                  saved_in = carried_ff;
               end
            end
         end
         BK_SQUARE: begin
            sqx_in = sqx_full;
            sqy_in = sqy_full;
         end
         BK_SUM: begin
            s_in    = sqx_ff + sqy_ff;
            root_in = '0;
            srem_in = '0;
            step_in = '0;
         end
         BK_SQRT: begin
            s_in    = {s_ff[SQ_W-3:0], 2'b00};
            root_in = {root_ff[LEN_W-2:0], sqrt_fits};
            srem_in = sqrt_fits ? srem_shift - sqrt_trial : srem_shift;
            step_in = step_ff + 1'b1;
         end
         BK_DIV_N: begin
            if (div_capture) begin
               if (ntot_zero) begin
                  carried_in = CARRY_W'(div_rsp.remainder);
               end else begin
                  trunc_in   = ntot_over;
                  n_in       = ntot_over ? N_W'(MAX_DABS) : div_rsp.quotient[N_W-1:0];
                  carried_in = ntot_over ? '0 : CARRY_W'(div_rsp.remainder);
                  t_in       = T_W'(spf) - T_W'(saved_ff);
                  k_in       = N_W'(1);
               end
            end
         end
         BK_DIV_XS, BK_DIV_YS, BK_DIV_X1, BK_DIV_Y1: begin
            if (phase_ff == PH_MUL) begin
               prod_in = mul_res;
            end
            if (div_capture) begin
               unique case (state_ff)
                  BK_DIV_XS: begin
                     qsx_in = floor_q;
                     rsx_in = floor_r;
                  end
                  BK_DIV_YS: begin
                     qsy_in = floor_q;
                     rsy_in = floor_r;
                  end
                  BK_DIV_X1: begin
                     qx_in = floor_q;
                     rx_in = floor_r;
                  end
                  default: begin
                     qy_in = floor_q;
                     ry_in = floor_r;
                  end
               endcase
            end
         end
         BK_WALK: begin
            if (out_free) begin
               k_in  = k_ff + 1'b1;
               t_in  = t_ff + T_W'(spf);
               rx_in = rx_carry ? rx_wrap[LEN_W-1:0] : rx_sum[LEN_W-1:0];
               ry_in = ry_carry ? ry_wrap[LEN_W-1:0] : ry_sum[LEN_W-1:0];
               qx_in = qx_ff + qsx_ff + (rx_carry ? Q_W'(1) : Q_W'(0));
               qy_in = qy_ff + qsy_ff + (ry_carry ? Q_W'(1) : Q_W'(0));
            end
         end
         default: begin
            k_in = k_ff;
         end
      endcase
   end

   // Output register: load a dab, drop it once taken
   always_comb begin
      rsp_item_in = out_load ? out_item : rsp_item_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         phase_ff     <= PH_MUL;
         rsp_valid_ff <= 1'b0;
         anchor_x_ff  <= '0;
         anchor_y_ff  <= '0;
         carried_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         anchor_x_ff  <= anchor_x_in;
         anchor_y_ff  <= anchor_y_in;
         carried_ff   <= carried_in;
      end
   end

   always_ff @(posedge clock) begin
      ax_ff       <= ax_in;
      ay_ff       <= ay_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      saved_ff    <= saved_in;
      sqx_ff      <= sqx_in;
      sqy_ff      <= sqy_in;
      s_ff        <= s_in;
      root_ff     <= root_in;
      srem_ff     <= srem_in;
      step_ff     <= step_in;
      prod_ff     <= prod_in;
      n_ff        <= n_in;
      k_ff        <= k_in;
      trunc_ff    <= trunc_in;
      t_ff        <= t_in;
      qsx_ff      <= qsx_in;
      qsy_ff      <= qsy_in;
      qx_ff       <= qx_in;
      qy_ff       <= qy_in;
      rsx_ff      <= rsx_in;
      rsy_ff      <= rsy_in;
      rx_ff       <= rx_in;
      ry_ff       <= ry_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

### design/stroke_dab_spacer.sv
// ----------------------------------------------------------------------------
// stroke_dab_spacer: evenly spaced brush dabs from pointer events
// Usage: pointer events (press, move, release) enter on the req_ channel as
// items; dab positions leave on the rsp_ channel, last set on the final dab
// of an event and truncated set on every dab of a move cut at the dab limit.
// The spacing register answers at csr_ addresses 0 to 3 (reset 1).
// The front classifies each event combinationally and queues presses and moves
// in a four-entry queue; releases and ignored events leave no item.
// A press at the queue head loads its dab into the output register when free.
// A move passes through squaring and summing, a square root (two radicand bits a
// cycle) and five divisions on the shared one-bit-per-cycle divider before its
// first dab; a move with a zero-length segment or no dab due skips most
// divisions. Dabs then follow one per cycle while the receiver takes them.
// Events are taken while the back works until the queue fills.
// Reset clears the drag, the anchor, the carried distance and the queue.
// When the receiver stalls, the output register holds its dab and the walk
// waits; nothing is dropped.
// ----------------------------------------------------------------------------
module stroke_dab_spacer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  sds_pkg::req_item_type         req_item,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output sds_pkg::rsp_item_type         rsp_item,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [sds_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [sds_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [sds_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                          csr_pready
);
   import sds_pkg::*;

   logic [SPACING_W-1:0] spacing_ff, spacing_in;
   logic                 csr_write;
   queue_push_type       push;
   queue_head_type       head;
   logic                 queue_full;
   logic                 pop;
   div_req_type          div_req;
   div_rsp_type          div_rsp;

   // Configuration register
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[CSR_ADDR_W-1] == REG_SPACING);
   assign spacing_in = csr_write ? csr_pwdata[SPACING_W-1:0] : spacing_ff;
   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1] == REG_SPACING)
                       ? CSR_DATA_W'(spacing_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         spacing_ff <= SPACING_RESET;
      end else begin
         spacing_ff <= spacing_in;
      end
   end

   sds_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .queue_full (queue_full),
      .push       (push)
   );

   sds_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (queue_full),
      .head  (head)
   );

   sds_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   sds_back u_back (
      .clock     (clock),
      .reset     (reset),
      .spacing   (spacing_ff),
      .head      (head),
      .pop       (pop),
      .div_req   (div_req),
      .div_rsp   (div_rsp),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

endmodule
